// ----- sv/r2a_pkg.sv -----
// Shared types, constants and the digit-to-character function of the radix converter.
package r2a_pkg;

   localparam int IN_W    = 32;   // width of the value field on the input port
   localparam int RADIX_W = 6;    // width of the radix register
   localparam int DIGIT_W = 6;    // one digit, 0 to 35
   localparam int CHAR_W  = 7;    // ASCII code of one digit

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

   localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;   // '0'
   localparam logic [CHAR_W-1:0]  ASCII_A_M10 = 7'h57;   // 'a' minus ten
   localparam logic [CHAR_W-1:0]  ASCII_NUL   = 7'h00;

   // Classification of one item, fixed at the time it is accepted.
   typedef struct packed {
      logic                bad_base;
      logic [RADIX_W-1:0]  radix;
   } r2a_class_type;

   localparam int CLASS_W = $bits(r2a_class_type);

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {1'b0, d};
      if (d < DIGIT_TEN) begin
         return d_ext + ASCII_ZERO;
      end else begin
         return d_ext + ASCII_A_M10;
      end
   endfunction

endpackage

// ----- sv/r2a_front.sv -----
// Front end: holds the radix register, masks the value and classifies each accepted item.
module r2a_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           full,
   input  logic [r2a_pkg::IN_W-1:0]       req_value,
   input  logic                           csr_we,
   input  logic [r2a_pkg::RADIX_W-1:0]    csr_wdata,
   output logic                           push,
   output logic [VALUE_BITS-1:0]          push_value,
   output r2a_pkg::r2a_class_type         push_class
);
   import r2a_pkg::*;

   logic [RADIX_W-1:0]  radix_ff;
   logic [RADIX_W-1:0]  radix_in;
   logic [2*IN_W-1:0]   value_wide;

   always_comb begin
      radix_in = radix_ff;
      if (csr_we) begin
         radix_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // Only the low VALUE_BITS bits of the value take part in the conversion.
   assign value_wide          = {{IN_W{1'b0}}, req_value};
   assign push_value          = value_wide[VALUE_BITS-1:0];
   assign push                = start && !full;
   assign push_class.radix    = radix_ff;
   assign push_class.bad_base = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);

endmodule

// ----- sv/r2a_queue.sv -----
// Two-entry queue that decouples the front end from the conversion engine.
module r2a_queue #(
   parameter int DATA_W = 39
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output logic [DATA_W-1:0] head_data
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   push_when_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   pop_when_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

// ----- sv/r2a_back.sv -----
// Conversion engine: bit-serial division by the radix, digit store and digit emission.
module r2a_back #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_not_empty,
   input  logic [VALUE_BITS-1:0]          q_value,
   input  r2a_pkg::r2a_class_type         q_class,
   output logic                           pop,
   output logic                           rsp_valid,
   output logic [r2a_pkg::CHAR_W-1:0]     rsp_digit_char,
   output logic                           rsp_last,
   output logic                           rsp_bad_base
);
   import r2a_pkg::*;

   localparam int BIT_CNT_W = $clog2(VALUE_BITS);
   localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_BITS - 1);
   localparam logic [DIG_IDX_W-1:0] DIG_LAST = DIG_IDX_W'(MAX_DIGITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   back_state_type         state_ff, state_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic [VALUE_BITS-1:0]  num_ff, num_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [DIG_IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic                   pend_last_ff, pend_last_in;
   logic                   pend_bad_ff, pend_bad_in;
   logic                   rsp_valid_ff;
   logic [CHAR_W-1:0]      rsp_char_ff;
   logic                   rsp_last_ff;
   logic                   rsp_bad_ff;

   logic [DIGIT_W-1:0]     dig_mem [MAX_DIGITS];
   logic [DIGIT_W-1:0]     rd_data_ff;
   logic                   mem_we;

   // One restoring-division step: shift in the next dividend bit, subtract if it fits.
   logic [DIGIT_W:0]       trial;
   logic                   fits;
   logic [DIGIT_W-1:0]     rem_step;
   logic [VALUE_BITS-1:0]  num_step;

   always_comb begin
      trial    = {rem_ff, num_ff[VALUE_BITS-1]};
      fits     = trial >= {1'b0, radix_ff};
      rem_step = fits ? DIGIT_W'(trial - {1'b0, radix_ff}) : trial[DIGIT_W-1:0];
      num_step = {num_ff[VALUE_BITS-2:0], fits};
   end

   always_comb begin
      state_in      = state_ff;
      radix_in      = radix_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      pend_valid_in = 1'b0;
      pend_last_in  = 1'b0;
      pend_bad_in   = 1'b0;
      pop           = 1'b0;
      mem_we        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               pop = 1'b1;
               if (q_class.bad_base) begin
                  pend_valid_in = 1'b1;
                  pend_last_in  = 1'b1;
                  pend_bad_in   = 1'b1;
               end else begin
                  radix_in   = q_class.radix;
                  num_in     = q_value;
                  rem_in     = '0;
                  bit_cnt_in = '0;
                  wr_idx_in  = '0;
                  state_in   = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            num_in = num_step;
            rem_in = rem_step;
            if (bit_cnt_ff == BIT_LAST) begin
               // The remainder is the next digit, the shifted dividend the quotient.
               mem_we     = 1'b1;
               rem_in     = '0;
               bit_cnt_in = '0;
               if ((num_step == '0) || (wr_idx_ff == DIG_LAST)) begin
                  rd_idx_in = wr_idx_ff;
                  state_in  = ST_EMIT;
               end else begin
                  wr_idx_in = wr_idx_ff + 1'b1;
               end
            end else begin
               bit_cnt_in = bit_cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            pend_valid_in = 1'b1;
            pend_last_in  = (rd_idx_ff == '0);
            if (rd_idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff     <= radix_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      wr_idx_ff    <= wr_idx_in;
      rd_idx_ff    <= rd_idx_in;
      pend_last_ff <= pend_last_in;
      pend_bad_ff  <= pend_bad_in;
      rsp_char_ff  <= pend_bad_ff ? ASCII_NUL : digit_to_char(rd_data_ff);
      rsp_last_ff  <= pend_last_ff;
      rsp_bad_ff   <= pend_bad_ff;
   end

   // Digit store: written least significant digit first, read back in reverse.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dig_mem[wr_idx_ff] <= rem_step;
      end
      rd_data_ff <= dig_mem[rd_idx_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_bad_base   = rsp_bad_ff;

   rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, rem_ff} < {1'b0, radix_ff}))
      else $error("partial remainder not below the radix");

   quiet_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ##2 !rsp_valid)
      else $error("result strobe while a division is running");

   error_item_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_base) |-> (rsp_last && (rsp_digit_char == ASCII_NUL)))
      else $error("bad-base result is not a single NUL item");

endmodule

// ----- sv/radix_to_ascii_converter.sv -----
// Top level of the radix converter: front end, item queue and conversion engine.
//
// Usage: an item is taken at a rising clock edge with start high and busy low; req_value
// carries the unsigned value, of which the low VALUE_BITS bits are converted. The block
// answers with one item per digit character, most significant first, each shown on the
// rsp_ ports for exactly one cycle while rsp_valid is high; rsp_last marks the final
// character of the value. Zero converts to a single '0'. Digits above nine are the
// lowercase letters. At most MAX_DIGITS characters are produced, the least significant
// ones when the value has more digits.
// The radix register is written through csr_we and csr_wdata and is sampled into each
// item at acceptance. If the radix lies outside 2 to 36, the item produces one NUL
// character with rsp_bad_base and rsp_last high, and no division is performed.
// Timing: the one-bit-per-cycle division unit, which produces the digits, sets the pace.
// The engine takes a new item only once it has issued the last character of the current one.
// Each character passes the pending and digit-store read registers, then the output
// registers; the NUL of a bad-base item passes the pending and output registers.
// A two-item queue sits before the engine, so busy rises only when two items wait.
// Reset (synchronous, active high) empties the queue, idles the engine and sets the
// radix to ten. The receiver cannot stall: results are never held back.
module radix_to_ascii_converter #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [r2a_pkg::IN_W-1:0]       req_value,
   output logic                           rsp_valid,
   output logic [r2a_pkg::CHAR_W-1:0]     rsp_digit_char,
   output logic                           rsp_last,
   output logic                           rsp_bad_base,
   input  logic                           csr_we,
   input  logic [r2a_pkg::RADIX_W-1:0]    csr_wdata
);
   import r2a_pkg::*;

   localparam int ENTRY_W = CLASS_W + VALUE_BITS;

   logic                   push;
   logic [VALUE_BITS-1:0]  push_value;
   r2a_class_type          push_class;
   logic                   q_full;
   logic                   q_not_empty;
   logic                   q_pop;
   logic [ENTRY_W-1:0]     q_head;
   r2a_class_type          head_class;
   logic [VALUE_BITS-1:0]  head_value;

   // The front end classifies the radix once, when the item is taken.
   r2a_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .full       (q_full),
      .req_value  (req_value),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_value (push_value),
      .push_class (push_class)
   );

   // Each queue entry holds the classification above the masked value.
   r2a_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_class, push_value}),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   assign head_class = q_head[ENTRY_W-1:VALUE_BITS];
   assign head_value = q_head[VALUE_BITS-1:0];

   // The engine divides, stores digits and plays them back most significant first.
   r2a_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_value        (head_value),
      .q_class        (head_class),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_bad_base   (rsp_bad_base)
   );

   // Only a full queue holds off new items.
   assign busy = q_full;

endmodule
